// ===== src/cbhf_pkg.sv =====
// package: constants, coefficient table and arithmetic helpers for the biquad cascade
package cbhf_pkg;

  localparam int NUM_SECTIONS_DEF   = 21;
  localparam int NUM_CHANNELS_DEF   = 2;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 30;

  localparam int DATA_W   = 48;
  localparam int COEF_W   = 32;
  localparam int FILT_W   = 32;
  localparam int TABLE_LEN = 21;
  localparam int NUM_TAPS = 5;
  localparam int PROD_W   = DATA_W + COEF_W;
  localparam int ACC_W    = PROD_W + 4;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic signed [COEF_W-1:0] ONEQ  = 32'sh4000_0000;
  localparam logic signed [COEF_W-1:0] MTWOQ = 32'sh8000_0000;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // q2.30 constants: gain, then a1, a2 of each high-pass pair
  function automatic coef_t q30(input longint unsigned d);
    return coef_t'((d * 64'd1048576 + 64'd4882812) / 64'd9765625);
  endfunction

  // raw q2.30 coefficient for section sec, tap k (b0 b1 b2 a1 a2)
  function automatic coef_t coef_raw(input int sec, input int k);
    longint unsigned g [10];
    longint unsigned p [10];
    longint unsigned q [10];
    int pr;
    g = '{64'd9560650587, 64'd9154215455, 64'd8794227242, 64'd8481743932,
          64'd8216649294, 64'd7998158932, 64'd7825190425, 64'd7696630955,
          64'd7611513734, 64'd7569138408};
    p = '{64'd18692123890, 64'd17897497420, 64'd17193682190, 64'd16582742930,
          64'd16064454320, 64'd15637280940, 64'd15299108030, 64'd15047760010,
          64'd14881346230, 64'd14798498150};
    q = '{64'd9550478458, 64'd8719363213, 64'd7983226776, 64'd7344233394,
          64'd6802144051, 64'd6355354786, 64'd6001653671, 64'd5738763213,
          64'd5564708114, 64'd5478054881};
    pr = sec / 2;
    if (sec >= TABLE_LEN - 1) begin
      return (k == 0) ? ONEQ : coef_t'(0);
    end else if (sec % 2 == 0) begin
      return (k == 0) ? q30(g[pr]) : coef_t'(0);
    end else begin
      unique case (k)
        0, 2:    return ONEQ;
        1:       return MTWOQ;
        3:       return -q30(p[pr]);
        default: return q30(q[pr]);
      endcase
    end
  endfunction

  // coefficient rescaled to frac fraction bits, round half up
  function automatic coef_t coef_get(input int sec, input int k, input int frac);
    longint c;
    int d;
    c = longint'(coef_raw(sec, k));
    d = 30 - frac;
    if (d == 0) return coef_t'(c);
    return coef_t'((c + (64'sd1 <<< (d - 1))) >>> d);
  endfunction

endpackage

// ===== src/cbhf_if.sv =====
// valid/ready channel interface with a generic payload
interface cbhf_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/cbhf_cell.sv =====
`default_nettype none
// one section cell: history of all channels of one section, ten-step mac on a half-width multiplier
module cbhf_cell #(
  parameter int NUM_CHANNELS   = cbhf_pkg::NUM_CHANNELS_DEF,
  parameter int SECTION        = 0,
  parameter int COEF_FRAC_BITS = cbhf_pkg::COEF_FRAC_BITS_DEF,
  parameter int CH_W           = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic                        clr,
  input  wire logic [CH_W-1:0]             ch,
  input  wire logic signed [cbhf_pkg::DATA_W-1:0] x_in,
  output logic                             done,
  output logic signed [cbhf_pkg::DATA_W-1:0] y_out
);
  import cbhf_pkg::*;

  localparam int STEP_W = 4;
  localparam int HALF_W = DATA_W / 2;
  localparam int MUL_W  = HALF_W + 1 + COEF_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * NUM_TAPS - 1);

  data_t x1 [NUM_CHANNELS];
  data_t x2 [NUM_CHANNELS];
  data_t y1 [NUM_CHANNELS];
  data_t y2 [NUM_CHANNELS];

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [STEP_W-2:0] tap;
  logic              hi_half;
  logic [CH_W-1:0]   cur;
  data_t             x0;
  logic signed [ACC_W-1:0]  acc;
  logic signed [HALF_W:0]   mul_a;
  logic signed [MUL_W-1:0]  prod;
  logic              prod_hi;
  logic              prod_v;
  logic              last_v;
  data_t             opnd;
  coef_t             cf;
  logic signed [ACC_W-1:0] part;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] shf;
  data_t             y_sat;

  // two steps per tap: low half of the operand first, then the high half
  assign tap     = step[STEP_W-1:1];
  assign hi_half = step[0];

  always_comb begin
    unique case (tap)
      3'd0:    begin opnd = x0;      cf = coef_get(SECTION, 0, COEF_FRAC_BITS); end
      3'd1:    begin opnd = x1[cur]; cf = coef_get(SECTION, 1, COEF_FRAC_BITS); end
      3'd2:    begin opnd = x2[cur]; cf = coef_get(SECTION, 2, COEF_FRAC_BITS); end
      3'd3:    begin opnd = y1[cur]; cf = -coef_get(SECTION, 3, COEF_FRAC_BITS); end
      default: begin opnd = y2[cur]; cf = -coef_get(SECTION, 4, COEF_FRAC_BITS); end
    endcase
  end

  // low half unsigned, high half signed
  assign mul_a = hi_half ? {opnd[DATA_W-1], opnd[DATA_W-1:HALF_W]}
                         : {1'b0, opnd[HALF_W-1:0]};

  // -coef of -2^31 is impossible for a1/a2 since they are never mtwoq
  assign part     = prod_hi ? (ACC_W'(prod) <<< HALF_W) : ACC_W'(prod);
  assign acc_next = acc + part;
  assign rnd = acc_next + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
  assign shf = rnd >>> COEF_FRAC_BITS;

  always_comb begin
    if (shf > ACC_W'(DATA_MAX))      y_sat = DATA_MAX;
    else if (shf < ACC_W'(DATA_MIN)) y_sat = DATA_MIN;
    else                             y_sat = shf[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      busy   <= 1'b0;
      prod_v <= 1'b0;
      last_v <= 1'b0;
      step   <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        x1[c] <= '0; x2[c] <= '0; y1[c] <= '0; y2[c] <= '0;
      end
    end else begin
      done <= !start && !busy && prod_v && last_v;
      if (clr) begin
        x1[ch] <= '0; x2[ch] <= '0; y1[ch] <= '0; y2[ch] <= '0;
      end
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        cur  <= ch;
        x0   <= x_in;
        acc  <= '0;
      end else if (busy) begin
        // multiply registered, accumulate on the next step
        prod    <= MUL_W'(mul_a * cf);
        prod_hi <= hi_half;
        prod_v  <= 1'b1;
        last_v  <= (step == LAST_STEP);
        if (prod_v) acc <= acc_next;
        if (step == LAST_STEP) busy <= 1'b0;
        else step <= step + 4'd1;
      end else if (prod_v) begin
        prod_v <= 1'b0;
        last_v <= 1'b0;
        if (last_v) begin
          y_out   <= y_sat;
          x2[cur] <= x1[cur];
          x1[cur] <= x0;
          y2[cur] <= y1[cur];
          y1[cur] <= y_sat;
        end
      end
    end
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy && !prod_v) else $error("cell restarted while busy");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(last_v)) else $error("done without final product");
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clr |-> !busy && !prod_v) else $error("clear during work");
`endif
endmodule
`default_nettype wire

// ===== src/cascaded_biquad_highpass_filter.sv =====
`default_nettype none
// top level: two-channel cascade of direct-form-i sections, gain and high-pass in turn
// Each filter word runs through NUM_SECTIONS cells in a row; every cell owns the
// tap history of its section for all channels and computes its five products on
// one pipelined half-width multiplier, two passes per product. The result of the
// last cell is rounded into the output register. One word is in flight at a time;
// the next input is taken once the result has left the output register. A clear
// word zeroes one channel's history and gives no result. Words naming an absent
// channel are dropped. History is reset.
module cascaded_biquad_highpass_filter #(
  parameter int NUM_SECTIONS   = cbhf_pkg::NUM_SECTIONS_DEF,
  parameter int NUM_CHANNELS   = cbhf_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS    = cbhf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = cbhf_pkg::COEF_FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  cbhf_if.sink     in_ch,
  cbhf_if.source   out_ch
);
  import cbhf_pkg::*;

  localparam int CH_W = 1;

  // input payload fields: op, channel, sample
  logic                   op;
  logic [CH_W-1:0]        channel;
  logic [SAMPLE_BITS-1:0] sample;
  assign op      = in_ch.data.op;
  assign channel = in_ch.data.channel;
  assign sample  = in_ch.data.sample;

  logic              busy;
  logic [CH_W-1:0]   cur;
  logic              out_valid;
  logic signed [FILT_W-1:0] filtered;
  logic [CH_W-1:0]   out_channel;

  logic              acc_in;
  logic              ch_ok;
  logic [NUM_SECTIONS:0] go;
  data_t             link [NUM_SECTIONS+1];
  data_t             x_first;
  data_t             y_last;
  data_t             y_rnd;
  data_t             y_shf;

  assign ch_ok  = (32'(channel) < NUM_CHANNELS);
  assign in_ch.ready = !busy && !out_valid;
  assign acc_in = in_ch.valid && in_ch.ready;

  // sample << 16 always fits in 48 bits for SAMPLE_BITS up to 31
  always_comb begin
    if (SAMPLE_BITS + 16 > DATA_W - 1 && sample[SAMPLE_BITS-1])
      x_first = DATA_MAX;
    else
      x_first = data_t'({sample, 16'd0});
  end

  assign go[0]   = acc_in && (op == OP_FILTER) && ch_ok;
  assign link[0] = x_first;

  // idle: the incoming word names the channel (start of cell 0, or a clear)
  for (genvar s = 0; s < NUM_SECTIONS; s++) begin : g_cell
    cbhf_cell #(
      .NUM_CHANNELS  (NUM_CHANNELS),
      .SECTION       (s),
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .CH_W          (CH_W)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .start(go[s]),
      .clr  (acc_in && (op == OP_CLEAR) && ch_ok),
      .ch   (busy ? cur : channel),
      .x_in (link[s]),
      .done (go[s+1]),
      .y_out(link[s+1])
    );
  end

  assign y_last = link[NUM_SECTIONS];
  // final rounding to an integer, round half up, then saturate to 32 bits
  assign y_rnd  = y_last + data_t'(32768);
  assign y_shf  = y_rnd >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go[0]) begin
        busy <= 1'b1;
        cur  <= channel;
      end
      if (go[NUM_SECTIONS]) begin
        busy        <= 1'b0;
        out_valid   <= 1'b1;
        out_channel <= cur;
        // overflow of y+half wraps only near max; guard with sign of y_last
        if (!y_last[DATA_W-1] && y_rnd[DATA_W-1])
          filtered <= 32'sh7FFF_FFFF;
        else if (y_shf > data_t'(32'sh7FFF_FFFF))
          filtered <= 32'sh7FFF_FFFF;
        else if (y_shf < data_t'(-64'sd2147483648))
          filtered <= 32'sh8000_0000;
        else
          filtered <= y_shf[FILT_W-1:0];
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.data.filtered    = filtered;
  assign out_ch.data.out_channel = out_channel;

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    go[0] |-> !busy && !out_valid) else $error("second word started");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(filtered))
    else $error("result dropped");
  a_end_when_busy: assert property (@(posedge clk) disable iff (rst)
    go[NUM_SECTIONS] |-> busy) else $error("result without word");
`endif
endmodule
`default_nettype wire
